// ===== rtl/wep_pkg.sv =====
// Shared types and constants of the wheel encoder period and speed block.
// Used by wep_speed_unit and wheel_encoder_period_speed_core; no dependencies.
package wep_pkg;

  // Timestamp arithmetic wraps at this many bits.
  localparam int unsigned TIME_BITS = 32;

  localparam int unsigned DEB_W    = 16;
  localparam int unsigned MINW_W   = 16;
  localparam int unsigned MAXW_W   = 32;
  localparam int unsigned CIRC_W   = 20;
  localparam int unsigned PPR_W    = 11;
  localparam int unsigned PERIOD_W = 32;
  localparam int unsigned SPEED_W  = 16;
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 32;

  // circumference * 1000 fits in CIRC_W + 10 bits
  localparam int unsigned NUM_W = CIRC_W + 10;
  localparam int unsigned DEN_W = PERIOD_W + PPR_W;
  // Divisor register holds the denominator shifted up by the quotient width
  localparam int unsigned DIV_W = DEN_W + SPEED_W;
  localparam int unsigned CNT_W = $clog2(SPEED_W + 1);

  // Input transaction kinds
  localparam logic [1:0] KIND_LEFT      = 2'd0;
  localparam logic [1:0] KIND_RIGHT     = 2'd1;
  localparam logic [1:0] KIND_CLR_MEAS  = 2'd2;
  localparam logic [1:0] KIND_CLR_COUNT = 2'd3;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_DEBOUNCE = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_MIN_W    = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_MAX_W    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_CIRC     = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_PPR      = 3'd4;

  // Reset values of the configuration registers
  localparam logic [DEB_W-1:0]  DEBOUNCE_RST = 16'd500;
  localparam logic [MINW_W-1:0] MIN_W_RST    = 16'd400;
  localparam logic [MAXW_W-1:0] MAX_W_RST    = 32'd10000000;
  localparam logic [CIRC_W-1:0] CIRC_RST     = 20'd331800;
  localparam logic [PPR_W-1:0]  PPR_RST      = 11'd20;

  typedef struct packed {
    logic [DEB_W-1:0]  debounce_us;
    logic [MINW_W-1:0] min_width_us;
    logic [MAXW_W-1:0] max_width_us;
    logic [CIRC_W-1:0] circumference_um;
    logic [PPR_W-1:0]  counts_per_turn;
  } cfg_t;

endpackage

// ===== rtl/wep_speed_unit.sv =====
// Shared speed unit: one multiply to form period * counts_per_turn, then a
// restoring divider, one quotient bit per cycle. Depends on wep_pkg.
module wep_speed_unit
  import wep_pkg::*;
(
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  input  logic [PERIOD_W-1:0] period,
  input  cfg_t                cfg,
  output logic                done,
  output logic [SPEED_W-1:0]  speed
);

  localparam logic [CNT_W-1:0] SAT_STEP = CNT_W'(SPEED_W);

  logic                busy_r;
  logic [CNT_W-1:0]    cnt_r;
  logic [DIV_W-1:0]    d_r;
  logic [NUM_W-1:0]    rem_r;
  logic [SPEED_W-2:0]  q_r;
  logic                sat_r;
  logic                zero_r;

  logic [DEN_W-1:0]    den;
  logic [NUM_W-1:0]    num;
  logic                out_of_range;
  logic                ge;

  always_comb begin
    den = DEN_W'(period) * DEN_W'(cfg.counts_per_turn);
    num = NUM_W'(cfg.circumference_um) * NUM_W'(1000);
    out_of_range = (period < PERIOD_W'(cfg.min_width_us)) ||
                   (period > cfg.max_width_us) ||
                   (period == '0) || (cfg.counts_per_turn == '0);
    ge    = {(DIV_W - NUM_W)'(0), rem_r} >= d_r;
    done  = busy_r && (cnt_r == '0);
    if (zero_r) begin
      speed = '0;
    end else if (sat_r) begin
      speed = '1;
    end else begin
      speed = {q_r, ge};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r  <= '0;
    end else if (start) begin
      busy_r <= 1'b1;
      cnt_r  <= SAT_STEP;
    end else if (busy_r) begin
      if (cnt_r == '0) begin
        busy_r <= 1'b0;
      end else begin
        cnt_r <= cnt_r - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      d_r    <= {den, SPEED_W'(0)};
      rem_r  <= num;
      zero_r <= out_of_range;
      sat_r  <= 1'b0;
    end else if (busy_r) begin
      // first step only checks whether the quotient overflows the speed field
      if (cnt_r == SAT_STEP) begin
        sat_r <= ge;
      end else begin
        if (ge) begin
          rem_r <= rem_r - d_r[NUM_W-1:0];
        end
        q_r <= {q_r[SPEED_W-3:0], ge};
      end
      d_r <= d_r >> 1;
    end
  end

endmodule

// ===== rtl/wheel_encoder_period_speed_core.sv =====
// Top level of the wheel encoder period and speed block: edge bookkeeping,
// configuration registers, sequencer and output register. Depends on wep_pkg
// and wep_speed_unit.

// Each input transaction updates the channel state in the cycle it is taken,
// then the two speeds are worked out one after the other in a single shared
// multiply-and-divide unit: a start state, a saturation check, then one divider
// step per quotient bit. A result goes to the output register once both speeds
// are done, and in_ready returns high together with out_valid, so no input is
// taken while the previous one is being worked out. A new input may then be
// taken while the previous result still waits on out_ready; if that result is
// still waiting when the next one is done, the sequencer holds, and in_ready
// with it. in_ready is low during reset. Configuration writes take effect at once
// and must only be issued while the block is idle.
module wheel_encoder_period_speed_core
  import wep_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic [1:0]            in_kind,
  input  logic [31:0]           in_timestamp_us,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic [PERIOD_W-1:0]   out_width_left,
  output logic [PERIOD_W-1:0]   out_width_right,
  output logic [31:0]           out_pulse_count,
  output logic [SPEED_W-1:0]    out_speed_left,
  output logic [SPEED_W-1:0]    out_speed_right,
  output logic                  out_accepted
);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_L_GO  = 3'd1;
  localparam logic [2:0] S_L_RUN = 3'd2;
  localparam logic [2:0] S_R_GO  = 3'd3;
  localparam logic [2:0] S_R_RUN = 3'd4;
  localparam logic [2:0] S_OUT   = 3'd5;

  localparam int unsigned EXT_W = TIME_BITS + PERIOD_W;

  cfg_t                  cfg_r;
  logic [2:0]            st_r, st_nxt;

  logic [TIME_BITS-1:0]  ref_l_r, ref_l_nxt, ref_r_r, ref_r_nxt;
  logic                  arm_l_r, arm_l_nxt, arm_r_r, arm_r_nxt;
  logic [PERIOD_W-1:0]   per_l_r, per_l_nxt, per_r_r, per_r_nxt;
  logic [31:0]           cnt_r, cnt_nxt;
  logic                  acc_r, acc_nxt;
  logic [SPEED_W-1:0]    spd_l_r, spd_r_r;

  logic                  out_valid_r;
  logic [PERIOD_W-1:0]   o_wl_r, o_wr_r;
  logic [31:0]           o_cnt_r;
  logic [SPEED_W-1:0]    o_sl_r, o_sr_r;
  logic                  o_acc_r;

  logic                  in_fire;
  logic                  load_out;
  logic [TIME_BITS-1:0]  t;
  logic [TIME_BITS-1:0]  ref_sel;
  logic [TIME_BITS-1:0]  diff;
  logic [EXT_W-1:0]      delta;
  logic                  deb_ok;
  logic [PERIOD_W-1:0]   per_new;

  logic                  su_start;
  logic [PERIOD_W-1:0]   su_period;
  logic                  su_done;
  logic [SPEED_W-1:0]    su_speed;

  assign in_ready  = rst_n && (st_r == S_IDLE);
  assign in_fire   = in_valid && in_ready;
  assign load_out  = (st_r == S_OUT) && (!out_valid_r || out_ready);
  assign out_valid = out_valid_r;
  assign out_width_left  = o_wl_r;
  assign out_width_right = o_wr_r;
  assign out_pulse_count = o_cnt_r;
  assign out_speed_left  = o_sl_r;
  assign out_speed_right = o_sr_r;
  assign out_accepted    = o_acc_r;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.debounce_us      <= DEBOUNCE_RST;
      cfg_r.min_width_us     <= MIN_W_RST;
      cfg_r.max_width_us     <= MAX_W_RST;
      cfg_r.circumference_um <= CIRC_RST;
      cfg_r.counts_per_turn  <= PPR_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_DEBOUNCE: cfg_r.debounce_us      <= cfg_wdata[DEB_W-1:0];
        REG_MIN_W:    cfg_r.min_width_us     <= cfg_wdata[MINW_W-1:0];
        REG_MAX_W:    cfg_r.max_width_us     <= cfg_wdata[MAXW_W-1:0];
        REG_CIRC:     cfg_r.circumference_um <= cfg_wdata[CIRC_W-1:0];
        REG_PPR:      cfg_r.counts_per_turn  <= cfg_wdata[PPR_W-1:0];
        default: ;
      endcase
    end
  end

  // Edge bookkeeping; the difference wraps at TIME_BITS and saturates to the period width
  always_comb begin
    t       = TIME_BITS'(in_timestamp_us);
    ref_sel = (in_kind == KIND_LEFT) ? ref_l_r : ref_r_r;
    diff    = t - ref_sel;
    delta   = EXT_W'(diff);
    deb_ok  = delta >= EXT_W'(cfg_r.debounce_us);
    per_new = (delta > EXT_W'({PERIOD_W{1'b1}})) ? '1 : delta[PERIOD_W-1:0];

    ref_l_nxt = ref_l_r;
    ref_r_nxt = ref_r_r;
    arm_l_nxt = arm_l_r;
    arm_r_nxt = arm_r_r;
    per_l_nxt = per_l_r;
    per_r_nxt = per_r_r;
    cnt_nxt   = cnt_r;
    acc_nxt   = acc_r;

    if (in_fire) begin
      acc_nxt = 1'b0;
      unique case (in_kind)
        KIND_LEFT: begin
          if (!arm_l_r) begin
            arm_l_nxt = 1'b1;
            ref_l_nxt = t;
          end else if (deb_ok) begin
            per_l_nxt = per_new;
            ref_l_nxt = t;
            acc_nxt   = 1'b1;
          end
        end
        KIND_RIGHT: begin
          if (!arm_r_r) begin
            arm_r_nxt = 1'b1;
            ref_r_nxt = t;
          end else if (deb_ok) begin
            per_r_nxt = per_new;
            ref_r_nxt = t;
            cnt_nxt   = cnt_r + 32'd1;
            acc_nxt   = 1'b1;
          end
        end
        KIND_CLR_MEAS: begin
          per_l_nxt = '0;
          per_r_nxt = '0;
          ref_l_nxt = '0;
          ref_r_nxt = '0;
          arm_l_nxt = 1'b0;
          arm_r_nxt = 1'b0;
        end
        KIND_CLR_COUNT: begin
          cnt_nxt = '0;
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ref_l_r <= '0;
      ref_r_r <= '0;
      arm_l_r <= 1'b0;
      arm_r_r <= 1'b0;
      per_l_r <= '0;
      per_r_r <= '0;
      cnt_r   <= '0;
      acc_r   <= 1'b0;
    end else begin
      ref_l_r <= ref_l_nxt;
      ref_r_r <= ref_r_nxt;
      arm_l_r <= arm_l_nxt;
      arm_r_r <= arm_r_nxt;
      per_l_r <= per_l_nxt;
      per_r_r <= per_r_nxt;
      cnt_r   <= cnt_nxt;
      acc_r   <= acc_nxt;
    end
  end

  // Sequencer: left speed, then right speed, then hand over to the output register
  always_comb begin
    st_nxt = st_r;
    unique case (st_r)
      S_IDLE:  if (in_fire) st_nxt = S_L_GO;
      S_L_GO:  st_nxt = S_L_RUN;
      S_L_RUN: if (su_done) st_nxt = S_R_GO;
      S_R_GO:  st_nxt = S_R_RUN;
      S_R_RUN: if (su_done) st_nxt = S_OUT;
      S_OUT:   if (load_out) st_nxt = S_IDLE;
      default: st_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= S_IDLE;
    end else begin
      st_r <= st_nxt;
    end
  end

  assign su_start  = (st_r == S_L_GO) || (st_r == S_R_GO);
  assign su_period = (st_r == S_L_GO) ? per_l_r : per_r_r;

  wep_speed_unit u_speed (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (su_start),
    .period (su_period),
    .cfg    (cfg_r),
    .done   (su_done),
    .speed  (su_speed)
  );

  always_ff @(posedge clk) begin
    if (st_r == S_L_RUN && su_done) begin
      spd_l_r <= su_speed;
    end
    if (st_r == S_R_RUN && su_done) begin
      spd_r_r <= su_speed;
    end
  end

  // Output register: hold the result transaction until out_ready
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (load_out) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      o_wl_r  <= per_l_r;
      o_wr_r  <= per_r_r;
      o_cnt_r <= cnt_r;
      o_sl_r  <= spd_l_r;
      o_sr_r  <= spd_r_r;
      o_acc_r <= acc_r;
    end
  end

endmodule
